### rtl/core/pid_angle_controller_assert.svh
// assertion macros for the pid angle controller
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef PID_ANGLE_CONTROLLER_ASSERT_SVH
`define PID_ANGLE_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define PAC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PAC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define PAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/core/pac_pkg.sv
// shared types, constants and width helpers for the pid angle controller
// no dependencies
package pac_pkg;

   localparam int DATA_W        = 24;
   localparam int GAIN_W        = 24;
   localparam int GAIN_FRAC     = 13;
   localparam int DRIVE_W       = 18;
   localparam int LIMIT_INT     = 500;
   localparam int WRAP_HALF_INT = 180;
   localparam int WRAP_FULL_INT = 360;
   localparam int FRAC_BITS_DEF = 8;
   localparam int ERR_W         = DATA_W + 2;
   localparam int DIF_W         = DATA_W + 1;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = (GAIN_W > DATA_W) ? GAIN_W : DATA_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_PROP   = 3'd0,
      CSR_GAIN_INTEG  = 3'd1,
      CSR_GAIN_DERIV  = 3'd2,
      CSR_TARGET_TRIM = 3'd3,
      CSR_WRAP_ENABLE = 3'd4,
      CSR_REVERSE_DIR = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] measured;
      logic signed [DATA_W-1:0] target;
   } req_word_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      drive_clipped;
   } rsp_word_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_prop;
      logic signed [GAIN_W-1:0] gain_integ;
      logic signed [GAIN_W-1:0] gain_deriv;
      logic signed [DATA_W-1:0] target_trim;
      logic                     wrap_enable;
      logic                     reverse_dir;
   } cfg_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   function automatic int signed_width(input int magnitude);
      return $clog2(magnitude + 1) + 1;
   endfunction

   function automatic int acc_width(input int frac_bits);
      return max_int(DRIVE_W, signed_width(LIMIT_INT * (1 << frac_bits)));
   endfunction

endpackage

### rtl/core/pac_error_stage.sv
// error, angle wrap, clamped integral and measurement difference
// depends on pac_pkg
module pac_error_stage import pac_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int ACC_W     = acc_width(FRAC_BITS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  req_word_type            in_word,
   output logic                    out_valid,
   input  logic                    out_stall,
   output logic signed [ERR_W-1:0] out_err,
   output logic signed [ACC_W-1:0] out_accum,
   output logic signed [DIF_W-1:0] out_diff
);

   localparam int FULL_W = signed_width(WRAP_FULL_INT * (1 << FRAC_BITS));
   localparam int XW     = max_int(ERR_W, FULL_W) + 1;
   localparam int SW     = max_int(ACC_W, ERR_W) + 1;
   localparam logic signed [XW-1:0] HALF_X = XW'(WRAP_HALF_INT * (1 << FRAC_BITS));
   localparam logic signed [XW-1:0] FULL_X = XW'(WRAP_FULL_INT * (1 << FRAC_BITS));
   localparam logic signed [SW-1:0] LIM_S  = SW'(LIMIT_INT * (1 << FRAC_BITS));

   logic                    valid_ff;
   logic signed [ACC_W-1:0] accum_ff, accum_in;
   logic signed [DATA_W-1:0] prev_ff;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [DIF_W-1:0] diff_ff, diff_in;
   logic signed [ERR_W-1:0] raw_err;
   logic signed [XW-1:0]    raw_x, wrap_x;
   logic signed [SW-1:0]    acc_sum, acc_clamp;
   logic                    take;

   assign in_stall = valid_ff && out_stall;
   assign take     = in_valid && !in_stall;

   assign raw_err = ERR_W'(in_word.target) + ERR_W'(cfg.target_trim)
                    - ERR_W'(in_word.measured);
   assign raw_x   = XW'(raw_err);

   always_comb begin
      wrap_x = raw_x;
      if (cfg.wrap_enable) begin
         if (raw_x > HALF_X) begin
            wrap_x = raw_x - FULL_X;
         end else if (raw_x < -HALF_X) begin
            wrap_x = raw_x + FULL_X;
         end
      end
   end

   assign err_in  = wrap_x[ERR_W-1:0];
   assign acc_sum = SW'(accum_ff) + SW'(err_in);

   always_comb begin
      acc_clamp = acc_sum;
      if (acc_sum > LIM_S) begin
         acc_clamp = LIM_S;
      end else if (acc_sum < -LIM_S) begin
         acc_clamp = -LIM_S;
      end
   end

   assign accum_in = acc_clamp[ACC_W-1:0];
   assign diff_in  = DIF_W'(in_word.measured) - DIF_W'(prev_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         accum_ff <= '0;
         prev_ff  <= '0;
      end else begin
         if (!in_stall) begin
            valid_ff <= in_valid;
         end
         if (take) begin
            accum_ff <= accum_in;
            prev_ff  <= in_word.measured;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         err_ff  <= err_in;
         diff_ff <= diff_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_err   = err_ff;
   assign out_accum = accum_ff;
   assign out_diff  = diff_ff;

endmodule

### rtl/core/pac_gain_stage.sv
// three gain multipliers with registered products
// depends on pac_pkg
module pac_gain_stage import pac_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int ACC_W     = acc_width(FRAC_BITS)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cfg_type                        cfg,
   input  logic                           in_valid,
   output logic                           in_stall,
   input  logic signed [ERR_W-1:0]        in_err,
   input  logic signed [ACC_W-1:0]        in_accum,
   input  logic signed [DIF_W-1:0]        in_diff,
   output logic                           out_valid,
   input  logic                           out_stall,
   output logic signed [GAIN_W+ERR_W-1:0] out_prod_p,
   output logic signed [GAIN_W+ACC_W-1:0] out_prod_i,
   output logic signed [GAIN_W+DIF_W-1:0] out_prod_d
);

   localparam int PP_W = GAIN_W + ERR_W;
   localparam int PI_W = GAIN_W + ACC_W;
   localparam int PD_W = GAIN_W + DIF_W;

   logic                   valid_ff;
   logic signed [PP_W-1:0] prod_p_ff, prod_p_in;
   logic signed [PI_W-1:0] prod_i_ff, prod_i_in;
   logic signed [PD_W-1:0] prod_d_ff, prod_d_in;
   logic                   take;

   assign in_stall = valid_ff && out_stall;
   assign take     = in_valid && !in_stall;

   assign prod_p_in = PP_W'(cfg.gain_prop)  * PP_W'(in_err);
   assign prod_i_in = PI_W'(cfg.gain_integ) * PI_W'(in_accum);
   assign prod_d_in = PD_W'(cfg.gain_deriv) * PD_W'(in_diff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_prod_p = prod_p_ff;
   assign out_prod_i = prod_i_ff;
   assign out_prod_d = prod_d_ff;

endmodule

### rtl/core/pac_output_stage.sv
// product sum, truncation toward zero, output clamp, reversal and result register
// depends on pac_pkg
module pac_output_stage import pac_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int ACC_W     = acc_width(FRAC_BITS)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cfg_type                        cfg,
   input  logic                           in_valid,
   output logic                           in_stall,
   input  logic signed [GAIN_W+ERR_W-1:0] in_prod_p,
   input  logic signed [GAIN_W+ACC_W-1:0] in_prod_i,
   input  logic signed [GAIN_W+DIF_W-1:0] in_prod_d,
   output logic                           out_valid,
   input  logic                           out_stall,
   output rsp_word_type                   out_word
);

   localparam int SUM_W = max_int(max_int(GAIN_W + ERR_W, GAIN_W + ACC_W), GAIN_W + DIF_W) + 2;
   localparam int Q_W   = SUM_W - GAIN_FRAC;
   localparam logic signed [Q_W-1:0] LIM_Q = Q_W'(LIMIT_INT * (1 << FRAC_BITS));

   logic                    valid_ff;
   rsp_word_type            word_ff, word_in;
   logic signed [SUM_W-1:0] sum_val;
   logic signed [Q_W-1:0]   quot_floor, quot_val, clamp_val, final_val;
   logic                    round_up, clip_val;
   logic                    take;

   assign in_stall = valid_ff && out_stall;
   assign take     = in_valid && !in_stall;

   assign sum_val    = SUM_W'(in_prod_p) + SUM_W'(in_prod_i) - SUM_W'(in_prod_d);
   assign quot_floor = sum_val[SUM_W-1:GAIN_FRAC];
   assign round_up   = sum_val[SUM_W-1] & (|sum_val[GAIN_FRAC-1:0]);
   assign quot_val   = quot_floor + Q_W'(round_up);

   always_comb begin
      clamp_val = quot_val;
      clip_val  = 1'b0;
      if (quot_val > LIM_Q) begin
         clamp_val = LIM_Q;
         clip_val  = 1'b1;
      end else if (quot_val < -LIM_Q) begin
         clamp_val = -LIM_Q;
         clip_val  = 1'b1;
      end
      final_val = cfg.reverse_dir ? -clamp_val : clamp_val;
   end

   assign word_in.drive         = final_val[DRIVE_W-1:0];
   assign word_in.drive_clipped = clip_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

### rtl/core/pid_angle_controller.sv
// one pid regulator channel with integral anti-windup and optional angle wrap
// top level: register file and three pipeline stages; depends on pac_pkg and
// pid_angle_controller_assert.svh
//
// takes one measured/target word per clock while not stalled and gives one drive word
// per word taken, registered by the error, gain and output stages in turn; the integral
// loop closes inside the error stage, so a new word may enter every cycle and the
// stages stall only when the result is held. gains and flags are sampled by the stage
// that uses them; write them while the block is idle, the block does not enforce it
`include "pid_angle_controller_assert.svh"
module pid_angle_controller import pac_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_word,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ACC_W = acc_width(FRAC_BITS);
   localparam logic signed [ACC_W-1:0] LIM_A = ACC_W'(LIMIT_INT * (1 << FRAC_BITS));

   cfg_type cfg_ff, cfg_in;

   logic                           s1_valid, s1_stall;
   logic signed [ERR_W-1:0]        s1_err;
   logic signed [ACC_W-1:0]        s1_accum;
   logic signed [DIF_W-1:0]        s1_diff;
   logic                           s2_valid, s2_stall;
   logic signed [GAIN_W+ERR_W-1:0] s2_prod_p;
   logic signed [GAIN_W+ACC_W-1:0] s2_prod_i;
   logic signed [GAIN_W+DIF_W-1:0] s2_prod_d;

   logic                           accum_in_window;
   logic                           s1_held;
   logic [ERR_W+ACC_W+DIF_W-1:0]   s1_bits;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_PROP:   cfg_in.gain_prop   = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_INTEG:  cfg_in.gain_integ  = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_DERIV:  cfg_in.gain_deriv  = csr_wdata[GAIN_W-1:0];
            CSR_TARGET_TRIM: cfg_in.target_trim = csr_wdata[DATA_W-1:0];
            CSR_WRAP_ENABLE: cfg_in.wrap_enable = csr_wdata[0];
            CSR_REVERSE_DIR: cfg_in.reverse_dir = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pac_error_stage #(
      .FRAC_BITS (FRAC_BITS),
      .ACC_W     (ACC_W)
   ) u_error (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_word   (req_word),
      .out_valid (s1_valid),
      .out_stall (s1_stall),
      .out_err   (s1_err),
      .out_accum (s1_accum),
      .out_diff  (s1_diff)
   );

   pac_gain_stage #(
      .FRAC_BITS (FRAC_BITS),
      .ACC_W     (ACC_W)
   ) u_gain (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (s1_valid),
      .in_stall   (s1_stall),
      .in_err     (s1_err),
      .in_accum   (s1_accum),
      .in_diff    (s1_diff),
      .out_valid  (s2_valid),
      .out_stall  (s2_stall),
      .out_prod_p (s2_prod_p),
      .out_prod_i (s2_prod_i),
      .out_prod_d (s2_prod_d)
   );

   pac_output_stage #(
      .FRAC_BITS (FRAC_BITS),
      .ACC_W     (ACC_W)
   ) u_output (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s2_valid),
      .in_stall  (s2_stall),
      .in_prod_p (s2_prod_p),
      .in_prod_i (s2_prod_i),
      .in_prod_d (s2_prod_d),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (rsp_word)
   );

   assign accum_in_window = (s1_accum <= LIM_A) && (s1_accum >= -LIM_A);
   assign s1_held         = s1_valid && s1_stall;
   assign s1_bits         = {s1_err, s1_accum, s1_diff};

   // integral never leaves the clamp window
   `PAC_ASSERT_IMPLY(a_accum_bounded, clock, reset, s1_valid, accum_in_window, "integral unclamped")
   // a result appears only after a product word was waiting
   `PAC_ASSERT_IMPLY(a_rsp_from_s2, clock, reset, $rose(rsp_valid), $past(s2_valid), "stray result")
   // a held error word keeps its contents
   `PAC_ASSERT_NEXT(a_s1_hold, clock, reset, s1_held, s1_valid && $stable(s1_bits), "error word moved")

endmodule

### tb/tb_pid_angle_controller.sv
`timescale 1ns / 100ps
// self-checking bench for the pid angle controller: directed corner words, a back-pressure
// burst and random phases under random gains, all scored against an in-bench predictor
// depends on pac_pkg and pid_angle_controller
module tb_pid_angle_controller;
   import pac_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int REPORT_LIMIT   = 10;
   localparam int HOLD_CYCLES    = 80;
   localparam int BURST_WORDS    = 40;
   localparam int RANDOM_PHASES  = 9;
   localparam int PHASE_WORDS    = 42;

   localparam int ONE_Q      = 1 << FRAC_BITS_DEF;
   localparam int LIMIT_Q    = LIMIT_INT * ONE_Q;
   localparam int HALF_Q     = WRAP_HALF_INT * ONE_Q;
   localparam int FULL_Q     = WRAP_FULL_INT * ONE_Q;
   localparam int UNITY_GAIN = 1 << GAIN_FRAC;
   localparam int DATA_MAX   = (1 << (DATA_W - 1)) - 1;
   localparam int DATA_MIN   = -(1 << (DATA_W - 1));
   localparam int GAIN_MAX   = (1 << (GAIN_W - 1)) - 1;
   localparam int GAIN_MIN   = -(1 << (GAIN_W - 1));

   // indexes past the register list, written to check they are ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_word_type           req_word  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   cfg_type      model_cfg     = '0;
   longint       integ_sum     = 0;
   longint       last_measured = 0;
   rsp_word_type drive_q[$];
   int           mismatch_count = 0;
   int           idle_cycles    = 0;
   int           hold_cycles    = 0;
   bit           stall_mode     = 1'b0;
   bit           send_idle      = 1'b0;

   pid_angle_controller uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #CLOCK_HALF clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic longint clamp_limit(input longint v, output logic hit);
      hit = 1'b1;
      if (v > LIMIT_Q) return LIMIT_Q;
      if (v < -LIMIT_Q) return -LIMIT_Q;
      hit = 1'b0;
      return v;
   endfunction

   function automatic rsp_word_type predict_drive(input req_word_type w);
      longint       meas;
      longint       err;
      longint       deriv;
      longint       sum;
      logic         hit;
      rsp_word_type r;
      meas = longint'($signed(w.measured));
      err  = longint'($signed(w.target)) + longint'($signed(model_cfg.target_trim)) - meas;
      if (model_cfg.wrap_enable) begin
         if (err > HALF_Q) err -= FULL_Q;
         else if (err < -HALF_Q) err += FULL_Q;
      end
      integ_sum     = clamp_limit(integ_sum + err, hit);
      deriv         = meas - last_measured;
      last_measured = meas;
      sum = longint'($signed(model_cfg.gain_prop)) * err
          + longint'($signed(model_cfg.gain_integ)) * integ_sum
          - longint'($signed(model_cfg.gain_deriv)) * deriv;
      sum = sum / longint'(UNITY_GAIN);
      sum = clamp_limit(sum, hit);
      if (model_cfg.reverse_dir) sum = -sum;
      r.drive         = sum[DRIVE_W-1:0];
      r.drive_clipped = hit;
      return r;
   endfunction

   function automatic logic [GAIN_W-1:0] rand_gain();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return GAIN_MAX;
      if (r < 20) return GAIN_MIN;
      if (r < 25) return '0;
      if (r < 45) return $urandom;
      return $urandom_range(0, 4 * UNITY_GAIN) - 2 * UNITY_GAIN;
   endfunction

   function automatic logic [DATA_W-1:0] rand_sample(input int span);
      if ($urandom_range(0, 4) == 0) return $urandom;
      return $urandom_range(0, 2 * span) - span;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, what);
   endtask

   // result scoreboard
   always @(posedge clock) begin : drive_check
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word: drive %0d clipped %0b",
                                      rsp_word.drive, rsp_word.drive_clipped));
         end else begin
            want = drive_q.pop_front();
            if (rsp_word.drive !== want.drive || rsp_word.drive_clipped !== want.drive_clipped)
               report_mismatch($sformatf("expected drive %0d clipped %0b, got drive %0d clipped %0b",
                                         want.drive, want.drive_clipped,
                                         rsp_word.drive, rsp_word.drive_clipped));
         end
      end
   end

   // receiver hold-off, random or one long stretch on request
   always begin : rsp_stall_gen
      int n;
      @(posedge clock);
      n = 0;
      if (hold_cycles > 0) begin
         n = hold_cycles;
         hold_cycles = 0;
      end else if (stall_mode && $urandom_range(0, 3) == 0) begin
         n = pick_gap() + 1;
      end
      if (n > 0) begin
         rsp_stall <= 1'b1;
         repeat (n) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_word(input logic [DATA_W-1:0] meas, input logic [DATA_W-1:0] tgt);
      req_word_type w;
      int           gap;
      w.measured = meas;
      w.target   = tgt;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      drive_q.push_back(predict_drive(w));
      gap = send_idle ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      if (req_valid) req_valid <= 1'b0;
      while (drive_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_GAIN_PROP:   model_cfg.gain_prop   = data[GAIN_W-1:0];
         CSR_GAIN_INTEG:  model_cfg.gain_integ  = data[GAIN_W-1:0];
         CSR_GAIN_DERIV:  model_cfg.gain_deriv  = data[GAIN_W-1:0];
         CSR_TARGET_TRIM: model_cfg.target_trim = data[DATA_W-1:0];
         CSR_WRAP_ENABLE: model_cfg.wrap_enable = data[0];
         CSR_REVERSE_DIR: model_cfg.reverse_dir = data[0];
         default: ;
      endcase
   endtask

   task automatic apply_cfg(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
                            input logic [GAIN_W-1:0] gd, input logic [DATA_W-1:0] trim,
                            input bit wrap, input bit rev);
      write_reg(CSR_GAIN_PROP, gp);
      write_reg(CSR_GAIN_INTEG, gi);
      write_reg(CSR_GAIN_DERIV, gd);
      write_reg(CSR_TARGET_TRIM, trim);
      write_reg(CSR_WRAP_ENABLE, $urandom & ~1 | wrap);
      write_reg(CSR_SPARE_LO, $urandom);
      write_reg(CSR_REVERSE_DIR, $urandom & ~1 | rev);
      write_reg(CSR_SPARE_HI, $urandom);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_random_cfg();
      logic [DATA_W-1:0] trim;
      trim = ($urandom_range(0, 9) == 0) ? $urandom : rand_sample(50 * ONE_Q);
      apply_cfg(rand_gain(), rand_gain(), rand_gain(), trim,
                $urandom_range(0, 1), $urandom_range(0, 1));
   endtask

   // first word after reset sees a derivative equal to the measurement
   task automatic test_first_step();
      apply_cfg(UNITY_GAIN, 0, UNITY_GAIN, 0, 1'b0, 1'b0);
      send_word(ONE_Q, ONE_Q);
      send_word(DATA_MAX, DATA_MIN);
      send_word(DATA_MIN, DATA_MAX);
      send_word(0, 0);
      send_word(0, LIMIT_Q);
      send_word(0, LIMIT_Q + 1);
   endtask

   task automatic test_gain_extremes();
      wait_drained();
      apply_cfg(GAIN_MAX, GAIN_MIN, GAIN_MAX, DATA_MIN, 1'b0, 1'b0);
      send_word(DATA_MAX, DATA_MIN);
      send_word(DATA_MIN, DATA_MAX);
      send_word(0, 0);
      wait_drained();
      apply_cfg(GAIN_MIN, GAIN_MAX, GAIN_MIN, DATA_MAX, 1'b0, 1'b0);
      send_word(DATA_MIN, DATA_MAX);
      send_word(DATA_MAX, DATA_MIN);
      send_word(0, 0);
   endtask

   // half-turn boundary, one step past it, and errors beyond one and a half turns
   task automatic test_angle_wrap();
      wait_drained();
      apply_cfg(UNITY_GAIN, 0, 0, 0, 1'b1, 1'b0);
      send_word(0, HALF_Q);
      send_word(0, -HALF_Q);
      send_word(0, HALF_Q + 1);
      send_word(0, -HALF_Q - 1);
      send_word(0, 3 * HALF_Q + 1);
      send_word(0, -3 * HALF_Q - 1);
      send_word(DATA_MIN, DATA_MAX);
   endtask

   task automatic test_reverse_action();
      wait_drained();
      apply_cfg(UNITY_GAIN, UNITY_GAIN, 0, 0, 1'b0, 1'b1);
      send_word(0, 3 * LIMIT_Q);
      send_word(0, -3 * LIMIT_Q);
      send_word(0, -3 * LIMIT_Q);
      send_word(0, 20 * ONE_Q);
   endtask

   // receiver holds off while the sender keeps offering words
   task automatic test_backpressure();
      wait_drained();
      apply_random_cfg();
      send_idle   = 1'b0;
      stall_mode  = 1'b0;
      hold_cycles = HOLD_CYCLES;
      repeat (BURST_WORDS) send_word(rand_sample(100 * ONE_Q), rand_sample(100 * ONE_Q));
   endtask

   task automatic test_random_phases();
      int span;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         apply_random_cfg();
         send_idle  = (p % 3) != 0;
         stall_mode = (p % 4) != 0;
         span = model_cfg.wrap_enable ? 400 * ONE_Q : 100 * ONE_Q;
         repeat (PHASE_WORDS) send_word(rand_sample(span), rand_sample(span));
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle  = 1'b1;
      stall_mode = 1'b1;
      test_first_step();
      test_gain_extremes();
      test_angle_wrap();
      test_reverse_action();
      test_backpressure();
      test_random_phases();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/pac_pkg.sv
rtl/core/pac_error_stage.sv
rtl/core/pac_gain_stage.sv
rtl/core/pac_output_stage.sv
rtl/core/pid_angle_controller.sv
tb/tb_pid_angle_controller.sv
